// ----- sv/lzns_pkg.sv -----
// ----------------------------------------------------------------------------
// lzns_pkg: shared types and constants of the nibble stream decompressor
// Decoder phases, the result record, fixed format constants and output queue sizing.
// ----------------------------------------------------------------------------
package lzns_pkg;

  // Decoder phases.
  typedef enum logic [2:0] {
    PH_HEADER,
    PH_CTRL,
    PH_LIT,
    PH_LITVAR,
    PH_OFF_HI,
    PH_OFF_LO,
    PH_MATCHVAR,
    PH_COPY
  } phase_t;

  // One result record as it leaves the block.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       byte_taken;
    logic       finished;
    logic       length_overflow;
  } result_t;

  localparam int unsigned HEADER_LAST   = 15;
  localparam int unsigned HDR_MODE_IDX  = 8;
  localparam int unsigned HDR_MMIN_IDX  = 9;
  localparam int unsigned HDR_CTRL_IDX  = 12;
  localparam int unsigned CTRL_BYTES    = 4;
  localparam int unsigned LITVAR_BIAS   = 22;
  localparam logic [3:0]  LIM_SHORT     = 4'd7;
  localparam logic [3:0]  LIM_LONG      = 4'd15;
  localparam logic [5:0]  VARINT_STEP   = 6'd7;
  localparam logic [5:0]  VARINT_SATMAX = 6'd63;

  // Depth of the output queue and the fill level at which input stalls.
  localparam int unsigned OQ_DEPTH      = 4;
  localparam int unsigned OQ_STALL_AT   = 3;

endpackage

// ----- sv/lzns_ram.sv -----
// ----------------------------------------------------------------------------
// lzns_ram: generic single-port-write, single-port-read synchronous RAM
// One write and one registered read per cycle; read returns old data.
// ----------------------------------------------------------------------------
module lzns_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/lzns_core.sv -----
// ----------------------------------------------------------------------------
// lzns_core: stream parser and copy sequencer
// Holds all decoder state, advances it once per accepted transaction and
// issues the history read and write addresses for literals and copies.
// ----------------------------------------------------------------------------
module lzns_core import lzns_pkg::*; #(
  parameter int AW = 16,
  parameter int LB = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic          action,
  input  logic [7:0]    in_byte,
  output result_t       res,
  output logic          is_copy,
  output logic          hist_wen,
  output logic [AW-1:0] hist_waddr,
  output logic [AW-1:0] hist_raddr
);

  localparam logic signed [LB+1:0] LEN_MAX = {2'b00, {LB{1'b1}}};

  phase_t              phase, phase_next;
  logic [AW-1:0]       wp, wp_next;
  logic [31:0]         cw, cw_next;
  logic [3:0]          hc, hc_next;
  logic                som, som_next;
  logic signed [7:0]   mm, mm_next;
  logic [LB-1:0]       rem, rem_next;
  logic [AW-1:0]       mdist, mdist_next;
  logic [5:0]          vs, vs_next;
  logic                ext, ext_next;
  logic [7:0]          asm_b, asm_b_next;
  logic                done, done_next;
  logic                ovf, ovf_next;

  logic                disp, do_bc;
  logic signed [LB+1:0] bc_total;
  logic [LB+6:0]       vsh;
  logic [6:0]          grp;
  logic [LB:0]         lv_total;
  logic [15:0]         off;
  logic [3:0]          lim;
  logic [2:0]          dlen;

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
      wp    <= '0;
      cw    <= '0;
      hc    <= '0;
      som   <= 1'b0;
      mm    <= '0;
      rem   <= '0;
      mdist <= '0;
      vs    <= '0;
      ext   <= 1'b0;
      asm_b <= '0;
      done  <= 1'b0;
      ovf   <= 1'b0;
    end else if (accept) begin
      phase <= phase_next;
      wp    <= wp_next;
      cw    <= cw_next;
      hc    <= hc_next;
      som   <= som_next;
      mm    <= mm_next;
      rem   <= rem_next;
      mdist <= mdist_next;
      vs    <= vs_next;
      ext   <= ext_next;
      asm_b <= asm_b_next;
      done  <= done_next;
      ovf   <= ovf_next;
    end
  end

  assign hist_waddr = wp;
  assign hist_raddr = wp - mdist;

  // One decoding step over the current state.
  always_comb begin
    phase_next = phase;
    wp_next    = wp;
    cw_next    = cw;
    hc_next    = hc;
    som_next   = som;
    mm_next    = mm;
    rem_next   = rem;
    mdist_next = mdist;
    vs_next    = vs;
    ext_next   = ext;
    asm_b_next = asm_b;
    done_next  = done;
    ovf_next   = ovf;
    res        = '0;
    is_copy    = 1'b0;
    hist_wen   = 1'b0;
    disp       = 1'b0;
    do_bc      = 1'b0;
    bc_total   = '0;
    grp        = in_byte[6:0];
    vsh        = (LB+7)'(grp) << vs;
    lv_total   = '0;
    off        = {asm_b, in_byte};
    lim        = ext ? LIM_LONG : LIM_SHORT;
    dlen       = '0;

    if (!done) begin
      if (phase == PH_COPY) begin
        // Copy one history byte.
        is_copy       = 1'b1;
        hist_wen      = 1'b1;
        res.out_valid = 1'b1;
        wp_next       = wp + AW'(1);
        rem_next      = rem - LB'(1);
        if (rem == LB'(1)) begin
          disp = 1'b1;
        end
      end else if (!action) begin
        res.byte_taken = 1'b1;
        // Varint group merge, used by both varint phases.
        if (phase == PH_LITVAR || phase == PH_MATCHVAR) begin
          if (grp != 7'd0) begin
            if (vs >= 6'(LB) || (|vsh[LB+6:LB])) begin
              ovf_next = 1'b1;
              rem_next = {LB{1'b1}};
            end else begin
              rem_next = rem | vsh[LB-1:0];
            end
          end
          vs_next = (vs > VARINT_SATMAX - VARINT_STEP) ? VARINT_SATMAX : vs + VARINT_STEP;
        end
        unique case (phase)
          PH_HEADER: begin
            if (hc == 4'(HDR_MODE_IDX)) begin
              som_next = (in_byte[3:0] != 4'd0);
            end
            if (hc == 4'(HDR_MMIN_IDX)) begin
              mm_next = $signed(in_byte);
            end
            if (hc >= 4'(HDR_CTRL_IDX)) begin
              cw_next = {cw[23:0], in_byte};
            end
            if (hc >= 4'(HEADER_LAST)) begin
              hc_next = '0;
              disp    = 1'b1;
            end else begin
              hc_next = hc + 4'd1;
            end
          end
          PH_CTRL: begin
            cw_next = {cw[23:0], in_byte};
            hc_next = hc + 4'd1;
            if (hc_next >= 4'(CTRL_BYTES)) begin
              hc_next = '0;
              if (cw_next == '0) begin
                done_next = 1'b1;
              end else if (ext) begin
                rem_next   = LB'(cw_next[31:28]);
                ext_next   = 1'b1;
                phase_next = PH_OFF_HI;
              end else begin
                disp = 1'b1;
              end
            end
          end
          PH_LIT: begin
            hist_wen       = 1'b1;
            res.out_valid  = 1'b1;
            res.out_byte   = in_byte;
            wp_next        = wp + AW'(1);
            rem_next       = rem - LB'(1);
            if (rem == LB'(1)) begin
              // End of the literal run.
              cw_next = {cw[27:0], 4'd0};
              if (!ext) begin
                disp = 1'b1;
              end else if (cw_next == '0) begin
                hc_next    = '0;
                phase_next = PH_CTRL;
              end else begin
                rem_next   = LB'(cw_next[31:28]);
                ext_next   = 1'b1;
                phase_next = PH_OFF_HI;
              end
            end
          end
          PH_LITVAR: begin
            if (!in_byte[7]) begin
              lv_total = {1'b0, rem_next} + (LB+1)'(LITVAR_BIAS);
              if (lv_total[LB]) begin
                ovf_next = 1'b1;
                rem_next = {LB{1'b1}};
              end else begin
                rem_next = lv_total[LB-1:0];
              end
              ext_next   = 1'b1;
              phase_next = PH_LIT;
            end
          end
          PH_OFF_HI: begin
            asm_b_next = in_byte;
            phase_next = PH_OFF_LO;
          end
          PH_OFF_LO: begin
            if (som) begin
              off     = {4'd0, off[11:0]};
              cw_next = {asm_b[7:4], cw[27:0]};
            end else begin
              cw_next = {cw[27:0], 4'd0};
            end
            mdist_next = AW'(17'(off) + 17'd1);
            if (rem == LB'(lim)) begin
              rem_next   = '0;
              vs_next    = '0;
              phase_next = PH_MATCHVAR;
            end else begin
              do_bc    = 1'b1;
              bc_total = (LB+2)'(mm) + $signed({2'b00, rem});
            end
          end
          PH_MATCHVAR: begin
            if (!in_byte[7]) begin
              do_bc    = 1'b1;
              bc_total = (LB+2)'(mm) + $signed({2'b00, rem_next})
                         + $signed((LB+2)'(lim));
            end
          end
          PH_COPY: begin
            phase_next = PH_HEADER;
          end
        endcase
      end
    end

    // Start of a match copy, or dispatch if the total length is not positive.
    if (do_bc) begin
      if (bc_total <= 0) begin
        disp = 1'b1;
      end else begin
        if (bc_total > LEN_MAX) begin
          ovf_next = 1'b1;
          rem_next = {LB{1'b1}};
        end else begin
          rem_next = bc_total[LB-1:0];
        end
        phase_next = PH_COPY;
      end
    end

    // Dispatch on the top control nibble.
    if (disp) begin
      ext_next = 1'b0;
      dlen     = cw_next[30:28];
      if (cw_next == '0) begin
        hc_next    = '0;
        phase_next = PH_CTRL;
      end else if (cw_next[31]) begin
        if (dlen != 3'd0) begin
          rem_next   = LB'(dlen);
          ext_next   = (dlen != 3'd7);
          phase_next = PH_LIT;
        end else begin
          rem_next   = '0;
          vs_next    = '0;
          phase_next = PH_LITVAR;
        end
      end else begin
        rem_next   = LB'(dlen);
        phase_next = PH_OFF_HI;
      end
    end

    res.finished        = done_next;
    res.length_overflow = ovf_next;
  end

endmodule

// ----- sv/lzns_out_fifo.sv -----
// ----------------------------------------------------------------------------
// lzns_out_fifo: small result queue in front of the output channel
// Decouples the decoder pipeline from stalls on the output side.
// ----------------------------------------------------------------------------
module lzns_out_fifo import lzns_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  input  logic    res_stall,
  output logic    res_valid,
  output result_t head,
  output logic [$clog2(OQ_DEPTH):0] count
);

  localparam int PW = $clog2(OQ_DEPTH);

  result_t        entries [OQ_DEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic           pop;

  assign res_valid = (count != '0);
  assign pop       = res_valid && !res_stall;
  assign head      = entries[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ----- sv/lz77_nibble_stream_decompressor.sv -----
// ----------------------------------------------------------------------------
// lz77_nibble_stream_decompressor: streaming LZ77 nibble-format decoder
// Parses header, control words, literals and matches; history lives in RAM.
//
//   channel | handshake          | payload
//   input   | in_valid, in_stall | action, in_byte
//   output  | res_valid, res_stall | out_byte, out_valid, byte_taken,
//           |                    | finished, length_overflow
//
// Each input transaction yields one result transaction; one per cycle is
// sustained while the output is not stalled. A result is registered into
// the history RAM read stage when its input is accepted and then into the
// result queue, from which it is offered. A copy that reads the byte the
// previous transaction is still writing gets that byte forwarded.
// Input stalls while the result queue and the read stage together hold
// three or more transactions.
// Synchronous reset clears all control state; history is not cleared.
// ----------------------------------------------------------------------------
module lz77_nibble_stream_decompressor import lzns_pkg::*; #(
  parameter int WINDOW_BYTES = 65536,
  parameter int LENGTH_BITS  = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       action,
  input  logic [7:0] in_byte,
  output logic       res_valid,
  input  logic       res_stall,
  output logic [7:0] out_byte,
  output logic       out_valid,
  output logic       byte_taken,
  output logic       finished,
  output logic       length_overflow
);

  localparam int AW = $clog2(WINDOW_BYTES);
  localparam int CW = $clog2(OQ_DEPTH) + 1;

  logic          accept;
  result_t       c_res;
  logic          c_copy, c_wen;
  logic [AW-1:0] c_waddr, c_raddr;
  logic [7:0]    rdata;

  logic          s1_valid, s1_copy, s1_wen, s1_fwd;
  result_t       s1_res;
  logic [AW-1:0] s1_waddr;
  logic [7:0]    fwd_data, s1_byte;
  result_t       s1_out, head;
  logic [CW-1:0] count;

  assign in_stall = ((count + CW'(s1_valid)) >= CW'(OQ_STALL_AT));
  assign accept   = in_valid && !in_stall;

  lzns_core #(.AW(AW), .LB(LENGTH_BITS)) u_core (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .action     (action),
    .in_byte    (in_byte),
    .res        (c_res),
    .is_copy    (c_copy),
    .hist_wen   (c_wen),
    .hist_waddr (c_waddr),
    .hist_raddr (c_raddr)
  );

  // Resolve the emitted byte: forwarded, read from history, or literal.
  always_comb begin
    s1_byte = s1_res.out_byte;
    if (s1_copy) begin
      s1_byte = s1_fwd ? fwd_data : rdata;
    end
    s1_out          = s1_res;
    s1_out.out_byte = s1_byte;
  end

  lzns_ram #(.WIDTH(8), .DEPTH(WINDOW_BYTES)) u_hist (
    .clk   (clk),
    .we    (s1_valid && s1_wen),
    .waddr (s1_waddr),
    .wdata (s1_byte),
    .re    (accept && c_copy),
    .raddr (c_raddr),
    .rdata (rdata)
  );

  // Second stage: waits for the history read and writes the byte back.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_res   <= c_res;
    s1_copy  <= c_copy;
    s1_wen   <= c_wen;
    s1_waddr <= c_waddr;
    s1_fwd   <= s1_valid && s1_wen && (s1_waddr == c_raddr);
    fwd_data <= s1_byte;
  end

  lzns_out_fifo u_oq (
    .clk       (clk),
    .rst       (rst),
    .push      (s1_valid),
    .push_data (s1_out),
    .res_stall (res_stall),
    .res_valid (res_valid),
    .head      (head),
    .count     (count)
  );

  assign out_byte        = head.out_byte;
  assign out_valid       = head.out_valid;
  assign byte_taken      = head.byte_taken;
  assign finished        = head.finished;
  assign length_overflow = head.length_overflow;

endmodule
